// File: design/audio_dma_double_buffer_unit_macros.svh
// Assertion macros shared by the audio DMA double buffer design.
// Assertions are written with a clock named clock and a reset named reset.
`ifndef AUDIO_DMA_DOUBLE_BUFFER_UNIT_MACROS_SVH
`define AUDIO_DMA_DOUBLE_BUFFER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check the consequent in the same cycle as the antecedent
`define ADBU_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("adbu assertion failed");
// Check the consequent in the cycle after the antecedent
`define ADBU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("adbu assertion failed");
`else
`define ADBU_ASSERT_SAME(label, ante, cons)
`define ADBU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/adbu_pkg.sv
// Shared types and constants for the audio DMA double buffer unit.
// No dependencies.
package adbu_pkg;

   localparam int LENGTH_BITS   = 18;
   localparam int FRAME_BITS    = LENGTH_BITS - 2;
   localparam int FUNC_BITS     = 2;
   localparam int REQ_DATA_BITS = ((LENGTH_BITS + 7) / 8) * 8;
   localparam int REQ_PAD_BITS  = REQ_DATA_BITS - LENGTH_BITS;
   localparam int RSP_DATA_BITS = ((LENGTH_BITS + 4 + 7) / 8) * 8;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - LENGTH_BITS - 4;

   // Request opcodes
   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_SUBMIT = 2'd0,
      FUNC_TICK   = 2'd1,
      FUNC_POLL   = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   typedef struct packed {
      func_type               func;
      logic [LENGTH_BITS-1:0] buf_bytes;
   } req_type;

   typedef struct packed {
      logic                   pending_full;
      logic                   current_busy;
      logic                   pending_replaced;
      logic [LENGTH_BITS-1:0] remaining_bytes;
      logic                   irq_event;
   } rsp_type;

endpackage

// File: design/adbu_in_stage.sv
// Input register of the audio DMA double buffer unit.
// Depends on adbu_pkg.
module adbu_in_stage
   import adbu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  req_type req_item,
   input  logic    advance,
   output logic    stage_valid,
   output req_type stage_item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   // Free when empty or when the held item moves on this cycle
   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the payload on each input transfer
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

// File: design/adbu_core.sv
// Buffer slot state and per-request update logic.
// Depends on adbu_pkg and the assertion macro header.
`include "audio_dma_double_buffer_unit_macros.svh"
module adbu_core
   import adbu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type req_item,
   output rsp_type rsp_item
);

   logic                  cur_valid_ff, cur_valid_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [FRAME_BITS-1:0] cur_frames_ff, cur_frames_in;
   logic [FRAME_BITS-1:0] pend_frames_ff, pend_frames_in;
   logic                  irq_ff, irq_in;
   logic [FRAME_BITS-1:0] frames;

   // Whole frames in the submitted length, low two bits dropped
   assign frames = req_item.buf_bytes[LENGTH_BITS-1:2];

   always_comb begin
      cur_valid_in     = cur_valid_ff;
      pend_valid_in    = pend_valid_ff;
      cur_frames_in    = cur_frames_ff;
      pend_frames_in   = pend_frames_ff;
      irq_in           = irq_ff;
      rsp_item         = '0;
      unique case (req_item.func)
         FUNC_SUBMIT: begin
            // Start at once when idle, else park in the pending slot; zero frames are ignored
            if (frames != '0) begin
               if (!cur_valid_ff) begin
                  cur_frames_in = frames;
                  cur_valid_in  = 1'b1;
               end else begin
                  rsp_item.pending_replaced = pend_valid_ff;
                  pend_frames_in = frames;
                  pend_valid_in  = 1'b1;
               end
            end
         end
         FUNC_TICK: begin
            // Count one frame down; on completion promote or go idle
            if (!cur_valid_ff) begin
               if (pend_valid_ff) begin
                  cur_frames_in = pend_frames_ff;
                  cur_valid_in  = 1'b1;
                  pend_valid_in = 1'b0;
                  irq_in        = 1'b1;
               end
            end else if (cur_frames_ff > FRAME_BITS'(1)) begin
               cur_frames_in = cur_frames_ff - FRAME_BITS'(1);
            end else begin
               irq_in = 1'b1;
               if (pend_valid_ff) begin
                  cur_frames_in = pend_frames_ff;
                  pend_valid_in = 1'b0;
               end else begin
                  cur_frames_in = '0;
                  cur_valid_in  = 1'b0;
               end
            end
         end
         FUNC_POLL: begin
            // Report and clear the completion flag
            rsp_item.irq_event = irq_ff;
            irq_in             = 1'b0;
         end
         FUNC_READ: begin
            if (cur_valid_ff) begin
               rsp_item.remaining_bytes = {cur_frames_ff, 2'b00};
            end
         end
         default: begin
         end
      endcase
      rsp_item.current_busy = cur_valid_in;
      rsp_item.pending_full = pend_valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff   <= 1'b0;
         pend_valid_ff  <= 1'b0;
         cur_frames_ff  <= '0;
         pend_frames_ff <= '0;
         irq_ff         <= 1'b0;
      end else if (advance) begin
         cur_valid_ff   <= cur_valid_in;
         pend_valid_ff  <= pend_valid_in;
         cur_frames_ff  <= cur_frames_in;
         pend_frames_ff <= pend_frames_in;
         irq_ff         <= irq_in;
      end
   end

   // A pending buffer only exists behind a playing one
   `ADBU_ASSERT_SAME(a_pend_needs_cur, pend_valid_ff, cur_valid_ff)
   // A playing buffer always has frames left
   `ADBU_ASSERT_SAME(a_cur_nonzero, cur_valid_ff, cur_frames_ff != '0)
   // Only a frame tick raises the interrupt
   `ADBU_ASSERT_NEXT(a_irq_from_tick, !irq_ff && !(advance && req_item.func == FUNC_TICK), !irq_ff)

endmodule

// File: design/adbu_out_stage.sv
// Result register of the audio DMA double buffer unit.
// Depends on adbu_pkg.
module adbu_out_stage
   import adbu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_item,
   output logic    can_load,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output rsp_type rsp_item
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type item_ff;

   // Room when empty or when the held result is taken this cycle
   assign can_load = !valid_ff || rsp_tready;
   assign valid_in = can_load ? load : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule

// File: design/audio_dma_double_buffer_unit.sv
// Audio DMA double buffer unit: current and pending buffer slots with frame countdown.
// Path: an accepted request waits in the input register until the result register has room.
// Throughput: one request per cycle without stalls, set by the input and result registers.
// Reset: synchronous, active high; clears both slots, the frame counts and the interrupt flag.
// Depends on adbu_pkg, adbu_in_stage, adbu_core and adbu_out_stage.
module audio_dma_double_buffer_unit
   import adbu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // buf_bytes [LENGTH_BITS-1:0], zero pad above
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // func
   input  logic [FUNC_BITS-1:0]     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // irq_event, remaining_bytes, pending_replaced, current_busy, pending_full, zero pad
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   req_type req_item;
   req_type stage_item;
   rsp_type core_rsp;
   rsp_type out_rsp;
   logic    stage_valid;
   logic    can_load;
   logic    advance;

   assign req_item.func      = func_type'(req_tuser);
   assign req_item.buf_bytes = req_tdata[LENGTH_BITS-1:0];

   // Move the held request through the logic when the result register has room
   assign advance = stage_valid && can_load;

   adbu_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_item    (req_item),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   adbu_core u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .req_item (stage_item),
      .rsp_item (core_rsp)
   );

   adbu_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_item  (core_rsp),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (out_rsp)
   );

   assign rsp_tdata = {{RSP_PAD_BITS{1'b0}}, out_rsp};

endmodule
